/* src/mqtt_packet_header_parser_unit_assert.svh */
// Assertion macros used by the parser back end (mqtt_php_back).
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef MQTT_PACKET_HEADER_PARSER_UNIT_ASSERT_SVH
`define MQTT_PACKET_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MPHP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MPHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mqtt_php_pkg.sv */
`default_nettype none

package mqtt_php_pkg;

    // Field widths.
    localparam int unsigned LEN_W   = 28;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned VHDR_W  = 17;

    // Control packet types that shape the body.
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_ID_LO   = 4'd4;
    localparam logic [3:0] TYPE_ID_HI   = 4'd11;

    // Largest remaining length after reset.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 28'hFFF_FFFF;

    // Parser phase, which is also the region tag of the byte.
    typedef enum logic [2:0] {
        PH_FIRST    = 3'd0,
        PH_LEN      = 3'd1,
        PH_TOPICLEN = 3'd2,
        PH_TOPIC    = 3'd3,
        PH_ID       = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_OTHER    = 3'd6
    } phase_t;

    // One pre-decoded stream byte as it sits in the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       cont;
    } byte_item_t;

endpackage

`default_nettype wire

/* src/mqtt_php_front.sv */
`default_nettype none

module mqtt_php_front
    import mqtt_php_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    output logic            q_valid,
    input  wire logic       q_ready,
    output byte_item_t      q_item
);

    byte_item_t fifo_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    byte_item_t in_item;

    // Pre-decode the incoming item: flag the continuation bit.
    always_comb begin
        in_item.data = s_data_byte;
        in_item.cont = s_data_byte[7];
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* src/mqtt_php_back.sv */
`default_nettype none

`include "mqtt_packet_header_parser_unit_assert.svh"

module mqtt_php_back
    import mqtt_php_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire byte_item_t        q_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LEN_W-1:0]  cfg_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_region,
    output logic [3:0]             m_packet_type,
    output logic [1:0]             m_qos_level,
    output logic                   m_retain_flag,
    output logic                   m_dup_flag,
    output logic [LEN_W-1:0]       m_remaining_length,
    output logic [WORD_W-1:0]      m_topic_length,
    output logic [WORD_W-1:0]      m_packet_id,
    output logic                   m_id_valid,
    output logic [LEN_W-1:0]       m_payload_length,
    output logic                   m_end_of_packet,
    output logic                   m_error
);

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [1:0]          lbi_reg, lbi_next;
    logic [LEN_W-1:0]    acc_reg, acc_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic [WORD_W-1:0]   tlen_reg, tlen_next;
    logic [WORD_W-1:0]   tleft_reg, tleft_next;
    logic [WORD_W-1:0]   pid_reg, pid_next;
    logic [1:0]          ids_reg, ids_next;
    logic [LEN_W-1:0]    max_len_reg;

    // Output register.
    logic                m_valid_reg;
    logic [2:0]          region_reg;
    logic [7:0]          ohdr_reg;
    logic [LEN_W-1:0]    olen_reg;
    logic [WORD_W-1:0]   otlen_reg;
    logic [WORD_W-1:0]   opid_reg;
    logic                oidv_reg;
    logic [LEN_W-1:0]    opay_reg;
    logic                oeop_reg;
    logic                oerr_reg;

    logic                advance;
    logic                eop, err;
    logic [LEN_W-1:0]    len_group;
    logic [3:0]          cur_type;
    logic                cur_qos_nz;
    logic [VHDR_W-1:0]   vhdr;
    logic [LEN_W-1:0]    vhdr_ext;
    logic [LEN_W-1:0]    pay;
    logic                idv;

    assign q_ready   = !m_valid_reg || m_ready;
    assign advance   = q_valid && q_ready;
    assign cfg_ready = 1'b1;

    assign cur_type   = hdr_reg[7:4];
    assign cur_qos_nz = (hdr_reg[2:1] != 2'd0);

    // Place the seven value bits of a length byte by its position.
    always_comb begin
        unique case (lbi_reg)
            2'd0: len_group = {21'd0, q_item.data[6:0]};
            2'd1: len_group = {14'd0, q_item.data[6:0], 7'd0};
            2'd2: len_group = {7'd0, q_item.data[6:0], 14'd0};
            2'd3: len_group = {q_item.data[6:0], 21'd0};
        endcase
    end

    // Next parser state for the item at the queue head.
    always_comb begin
        phase_next = phase_reg;
        lbi_next   = lbi_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        hdr_next   = hdr_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        pid_next   = pid_reg;
        ids_next   = ids_reg;
        eop        = 1'b0;
        err        = 1'b0;
        unique case (phase_reg)
            PH_FIRST: begin
                hdr_next   = q_item.data;
                lbi_next   = 2'd0;
                acc_next   = '0;
                left_next  = '0;
                tlen_next  = '0;
                tleft_next = '0;
                pid_next   = '0;
                ids_next   = 2'd0;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                acc_next = acc_reg | len_group;
                if (q_item.cont) begin
                    if (lbi_reg == 2'd3) begin
                        err        = 1'b1;
                        phase_next = PH_FIRST;
                        lbi_next   = 2'd0;
                    end else begin
                        lbi_next = lbi_reg + 2'd1;
                    end
                end else if (acc_next > max_len_reg) begin
                    err        = 1'b1;
                    phase_next = PH_FIRST;
                    lbi_next   = 2'd0;
                end else begin
                    lbi_next  = 2'd0;
                    left_next = acc_next;
                    if (acc_next == '0) begin
                        eop        = 1'b1;
                        phase_next = PH_FIRST;
                    end else if (cur_type == TYPE_PUBLISH) begin
                        phase_next = PH_TOPICLEN;
                    end else if (cur_type >= TYPE_ID_LO && cur_type <= TYPE_ID_HI) begin
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_OTHER;
                    end
                end
            end
            default: begin
                // Body byte: advance the sub-field, then count down the packet.
                unique case (phase_reg)
                    PH_TOPICLEN: begin
                        if (lbi_reg == 2'd0) begin
                            tlen_next = {q_item.data, 8'd0};
                            lbi_next  = 2'd1;
                        end else begin
                            tlen_next  = tlen_reg | {8'd0, q_item.data};
                            lbi_next   = 2'd2;
                            tleft_next = tlen_next;
                            if (tlen_next != '0) begin
                                phase_next = PH_TOPIC;
                            end else begin
                                phase_next = cur_qos_nz ? PH_ID : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_TOPIC: begin
                        tleft_next = tleft_reg - 16'd1;
                        if (tleft_next == '0) begin
                            phase_next = cur_qos_nz ? PH_ID : PH_PAYLOAD;
                        end
                    end
                    PH_ID: begin
                        if (ids_reg == 2'd0) begin
                            pid_next = {q_item.data, 8'd0};
                            ids_next = 2'd1;
                        end else begin
                            pid_next   = pid_reg | {8'd0, q_item.data};
                            ids_next   = 2'd2;
                            phase_next = (cur_type == TYPE_PUBLISH) ? PH_PAYLOAD : PH_OTHER;
                        end
                    end
                    default: begin
                    end
                endcase
                left_next = left_reg - 28'd1;
                if (left_next == '0) begin
                    eop        = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
        endcase
    end

    // Payload length once the topic length is known.
    always_comb begin
        vhdr     = VHDR_W'(2) + {1'b0, tlen_next} + (hdr_next[2:1] != 2'd0 ? VHDR_W'(2)
                                                                       : VHDR_W'(0));
        vhdr_ext = {{(LEN_W-VHDR_W){1'b0}}, vhdr};
        pay      = '0;
        if (hdr_next[7:4] == TYPE_PUBLISH && lbi_next == 2'd2 && phase_next != PH_LEN) begin
            pay = (acc_next > vhdr_ext) ? (acc_next - vhdr_ext) : '0;
        end
        idv = (ids_next == 2'd2);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            lbi_reg     <= 2'd0;
            max_len_reg <= MAX_LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                lbi_reg   <= lbi_next;
            end
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Parser data and result item registers.
    always_ff @(posedge aclk) begin
        if (advance) begin
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            hdr_reg    <= hdr_next;
            tlen_reg   <= tlen_next;
            tleft_reg  <= tleft_next;
            pid_reg    <= pid_next;
            ids_reg    <= ids_next;
            region_reg <= phase_reg;
            ohdr_reg   <= hdr_next;
            olen_reg   <= acc_next;
            otlen_reg  <= tlen_next;
            opid_reg   <= idv ? pid_next : '0;
            oidv_reg   <= idv;
            opay_reg   <= pay;
            oeop_reg   <= eop;
            oerr_reg   <= err;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_region           = region_reg;
    assign m_packet_type      = ohdr_reg[7:4];
    assign m_qos_level        = ohdr_reg[2:1];
    assign m_retain_flag      = ohdr_reg[0];
    assign m_dup_flag         = ohdr_reg[3];
    assign m_remaining_length = olen_reg;
    assign m_topic_length     = otlen_reg;
    assign m_packet_id        = opid_reg;
    assign m_id_valid         = oidv_reg;
    assign m_payload_length   = opay_reg;
    assign m_end_of_packet    = oeop_reg;
    assign m_error            = oerr_reg;

    // A malformed length only ever shows on a length byte.
    `MPHP_ASSERT_IMPLIES(a_err_on_len, m_valid_reg && oerr_reg, region_reg == PH_LEN,
        "error raised outside the length field")
    // An item never both errors and ends a packet.
    `MPHP_ASSERT_IMPLIES(a_err_not_eop, m_valid_reg, !(oerr_reg && oeop_reg),
        "error and end of packet on the same item")
    // The packet id cannot be complete in the fixed header.
    `MPHP_ASSERT_IMPLIES(a_idv_in_body, m_valid_reg && oidv_reg,
        region_reg != PH_FIRST && region_reg != PH_LEN, "packet id valid in fixed header")
    // Only PUBLISH carries a payload length.
    `MPHP_ASSERT_IMPLIES(a_pay_publish, m_valid_reg && (opay_reg != '0),
        ohdr_reg[7:4] == TYPE_PUBLISH, "payload length on a non-publish packet")
    // After an end of packet or an error the parser waits for a first byte.
    `MPHP_ASSERT_NEXT(a_resync, advance && (eop || err), phase_reg == PH_FIRST,
        "parser did not return to the first byte")

endmodule

`default_nettype wire

/* src/mqtt_packet_header_parser_unit.sv */
`default_nettype none

// MQTT 3.1.1 fixed/variable header parser. Feed the byte stream one item per byte on the
// s_ channel; each byte yields exactly one m_ item carrying its region tag, the decoded
// first-byte fields, remaining length, topic length, packet id and PUBLISH payload length,
// plus end-of-packet and error flags. One byte is taken per clock when the output is
// drained; a byte waits in a two-entry input queue, then the parser reads it from the
// queue head and writes its result item into the output register. The limit on the
// remaining length is written on the cfg channel; the user must write it only while no
// byte is in flight, as the block itself does not enforce it.
module mqtt_packet_header_parser_unit
    import mqtt_php_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LEN_W-1:0]  cfg_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_region,
    output logic [3:0]             m_packet_type,
    output logic [1:0]             m_qos_level,
    output logic                   m_retain_flag,
    output logic                   m_dup_flag,
    output logic [LEN_W-1:0]       m_remaining_length,
    output logic [WORD_W-1:0]      m_topic_length,
    output logic [WORD_W-1:0]      m_packet_id,
    output logic                   m_id_valid,
    output logic [LEN_W-1:0]       m_payload_length,
    output logic                   m_end_of_packet,
    output logic                   m_error
);

    logic       q_valid;
    logic       q_ready;
    byte_item_t q_item;

    // Input queue with byte pre-decode.
    mqtt_php_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // Header parser and result register.
    mqtt_php_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_item             (q_item),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_region           (m_region),
        .m_packet_type      (m_packet_type),
        .m_qos_level        (m_qos_level),
        .m_retain_flag      (m_retain_flag),
        .m_dup_flag         (m_dup_flag),
        .m_remaining_length (m_remaining_length),
        .m_topic_length     (m_topic_length),
        .m_packet_id        (m_packet_id),
        .m_id_valid         (m_id_valid),
        .m_payload_length   (m_payload_length),
        .m_end_of_packet    (m_end_of_packet),
        .m_error            (m_error)
    );

endmodule

`default_nettype wire
